>>> design/ncc_pkg.sv
`default_nettype none

package ncc_pkg;

   // Field widths of the request and response
   localparam int FIELD_W     = 16;
   localparam int IN_COORDS   = 4;
   localparam int SLOT_W      = 4;
   localparam int DIST_W      = 34;
   localparam int NCENT_W     = 5;
   localparam int NDIMS_W     = 3;
   localparam int DCNT_W      = 4;

   // Parameter defaults
   localparam int DEF_MAX_CENTERS = 16;
   localparam int DEF_MAX_DIMS    = 4;
   localparam int DEF_COORD_BITS  = 16;

   // Register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CENTERS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS        = 1'b1;

   // Request function codes
   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [SLOT_W-1:0]         center_slot;
      logic signed [FIELD_W-1:0] coord_a;
      logic signed [FIELD_W-1:0] coord_b;
      logic signed [FIELD_W-1:0] coord_c;
      logic signed [FIELD_W-1:0] coord_d;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] nearest_slot;
      logic [DIST_W-1:0] best_dist_sq;
   } rsp_type;

   // Tag that travels alongside one center through the distance pipeline
   typedef struct packed {
      logic vld;
      logic last;
   } dist_tag_type;

   // Width of a full squared distance: one square per lane plus growth of the sum
   function automatic int sum_width(input int dims, input int coord_bits);
      return 2 * coord_bits + 1 + $clog2(dims);
   endfunction

endpackage

`default_nettype wire

>>> design/ncc_dist_unit.sv
`default_nettype none

module ncc_dist_unit import ncc_pkg::*; #(
   parameter int MAX_DIMS   = DEF_MAX_DIMS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dist_tag_type                       in_tag,
   input  wire logic [MAX_DIMS*COORD_BITS-1:0]     point,
   input  wire logic [MAX_DIMS*COORD_BITS-1:0]     center,
   input  wire logic                               center_ok,
   input  wire logic [MAX_DIMS-1:0]                lane_en,
   output dist_tag_type                            out_tag,
   output logic [sum_width(MAX_DIMS, COORD_BITS)-1:0] out_sum
);

   localparam int SQ_W  = 2 * COORD_BITS + 1;
   localparam int SUM_W = sum_width(MAX_DIMS, COORD_BITS);

   logic [SQ_W-1:0]  sq_ff [MAX_DIMS];
   dist_tag_type     tag_sq_ff;
   dist_tag_type     tag_sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum_ff;

   // One square per lane; an entry never written reads as zero
   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
      logic signed [COORD_BITS-1:0]   pt_c;
      logic signed [COORD_BITS-1:0]   ct_c;
      logic signed [COORD_BITS:0]     diff;
      logic signed [2*COORD_BITS+1:0] prod;

      assign pt_c = point[d*COORD_BITS +: COORD_BITS];
      assign ct_c = center_ok ? center[d*COORD_BITS +: COORD_BITS] : '0;
      assign diff = (COORD_BITS+1)'(pt_c) - (COORD_BITS+1)'(ct_c);
      assign prod = (2*COORD_BITS+2)'(diff) * (2*COORD_BITS+2)'(diff);

      always_ff @(posedge clock) begin
         sq_ff[d] <= lane_en[d] ? prod[SQ_W-1:0] : '0;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         sum_in = sum_in + SUM_W'(sq_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_sq_ff  <= '0;
         tag_sum_ff <= '0;
      end else begin
         tag_sq_ff  <= in_tag;
         tag_sum_ff <= tag_sq_ff;
      end
   end

   assign out_tag = tag_sum_ff;
   assign out_sum = sum_ff;

endmodule

`default_nettype wire

>>> design/nearest_center_classifier_unit.sv
// Nearest-center classifier.
// Requests arrive on req_valid/req_ready carrying one req_type. A load request
// (func 0) writes the four coordinates into the center entry named by
// center_slot and gives no response; the block stays ready. A classify request
// (func 1) scans the first num_centers entries over the first dims coordinates
// and returns the index of the nearest center and the squared distance on
// rsp_valid/rsp_ready; equal distances keep the lower index.
// The center table sits in one synchronous memory read once per cycle; each
// center goes through memory read, square, sum and compare, and the winner then
// goes to the response register. No new request is taken until that load.
// The response register is separate from the scan, so further requests are
// taken while a response waits; if a second scan finishes before the first
// response is taken, the block holds its result and accepts nothing until the
// receiver takes the earlier one. Reset clears every center to zero (per-entry
// valid flags, no sweep) and sets num_centers to 1 and dims to 4. Registers are
// written on csr_we; the user keeps to idle only, the block does not enforce it.
`default_nettype none

module nearest_center_classifier_unit import ncc_pkg::*; #(
   parameter int MAX_CENTERS = DEF_MAX_CENTERS,
   parameter int MAX_DIMS    = DEF_MAX_DIMS,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CNT_W  = (CIDX_W + 1 > NCENT_W) ? CIDX_W + 1 : NCENT_W;
   localparam int WORD_W = MAX_DIMS * COORD_BITS;
   localparam int EXT_W  = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
   localparam int SUM_W  = sum_width(MAX_DIMS, COORD_BITS);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   logic [NCENT_W-1:0] num_centers_ff;
   logic [NDIMS_W-1:0] dims_ff;

   logic                    req_fire;
   logic [FIELD_W-1:0]      in_coord [IN_COORDS];
   logic [WORD_W-1:0]       in_word;
   logic                    slot_in_range;

   logic [WORD_W-1:0]       center_mem [MAX_CENTERS];
   logic                    entry_vld_ff [MAX_CENTERS];
   logic [WORD_W-1:0]       rd_data_ff;
   logic                    rd_ok_ff;
   dist_tag_type            rd_tag_ff;

   logic [WORD_W-1:0]       pt_ff;
   logic [MAX_DIMS-1:0]     lane_en_ff, lane_en_in;
   logic [CIDX_W-1:0]       last_idx_ff, last_idx_in;
   logic [CIDX_W-1:0]       rd_idx_ff;
   logic                    issue_on_ff;

   dist_tag_type            dist_tag;
   logic [SUM_W-1:0]        dist_sum;
   logic [CIDX_W-1:0]       cmp_idx_ff;
   logic [CIDX_W-1:0]       best_idx_ff;
   logic [SUM_W-1:0]        best_sum_ff;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   logic                    rsp_load;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_centers_ff <= NCENT_W'(1);
         dims_ff        <= NDIMS_W'(4);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_CENTERS: num_centers_ff <= csr_wdata[NCENT_W-1:0];
            CSR_DIMS:        dims_ff        <= csr_wdata[NDIMS_W-1:0];
            default:         ;
         endcase
      end
   end

   // Convert the request coordinates to stored width; lanes past the fields are zero
   assign in_coord[0] = req_data.coord_a;
   assign in_coord[1] = req_data.coord_b;
   assign in_coord[2] = req_data.coord_c;
   assign in_coord[3] = req_data.coord_d;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_word
      if (d < IN_COORDS) begin : g_field
         logic signed [EXT_W-1:0] ext;
         assign ext = EXT_W'(signed'(in_coord[d]));
         assign in_word[d*COORD_BITS +: COORD_BITS] = ext[COORD_BITS-1:0];
      end else begin : g_zero
         assign in_word[d*COORD_BITS +: COORD_BITS] = '0;
      end
   end

   assign slot_in_range = (int'(req_data.center_slot) < MAX_CENTERS);

   // Effective search range, clamped to the table
   always_comb begin
      logic [CNT_W-1:0]  k;
      logic [DCNT_W-1:0] nd;
      k = CNT_W'(num_centers_ff);
      if (k == '0) begin
         k = CNT_W'(1);
      end else if (k > CNT_W'(MAX_CENTERS)) begin
         k = CNT_W'(MAX_CENTERS);
      end
      last_idx_in = CIDX_W'(k - CNT_W'(1));
      nd = DCNT_W'(dims_ff);
      if (nd == '0) begin
         nd = DCNT_W'(1);
      end else if (nd > DCNT_W'(MAX_DIMS)) begin
         nd = DCNT_W'(MAX_DIMS);
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         lane_en_in[d] = (DCNT_W'(d) < nd);
      end
   end

   // Center memory: write on a load request, one registered read per cycle
   always_ff @(posedge clock) begin
      if (req_fire && req_data.func == FUNC_LOAD && slot_in_range) begin
         center_mem[CIDX_W'(req_data.center_slot)] <= in_word;
      end
      rd_data_ff <= center_mem[rd_idx_ff];
      rd_ok_ff   <= entry_vld_ff[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CENTERS; c++) begin
            entry_vld_ff[c] <= 1'b0;
         end
      end else if (req_fire && req_data.func == FUNC_LOAD && slot_in_range) begin
         entry_vld_ff[CIDX_W'(req_data.center_slot)] <= 1'b1;
      end
   end

   // Capture the point and the search range at acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pt_ff       <= in_word;
         lane_en_ff  <= lane_en_in;
         last_idx_ff <= last_idx_in;
      end
   end

   // Read issue: one center per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
         rd_idx_ff   <= '0;
         rd_tag_ff   <= '0;
      end else begin
         rd_tag_ff.vld  <= issue_on_ff;
         rd_tag_ff.last <= issue_on_ff && (rd_idx_ff == last_idx_ff);
         if (req_fire && req_data.func == FUNC_CLASSIFY) begin
            issue_on_ff <= 1'b1;
            rd_idx_ff   <= '0;
         end else if (issue_on_ff) begin
            if (rd_idx_ff == last_idx_ff) begin
               issue_on_ff <= 1'b0;
            end else begin
               rd_idx_ff <= rd_idx_ff + CIDX_W'(1);
            end
         end
      end
   end

   ncc_dist_unit #(
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (rd_tag_ff),
      .point     (pt_ff),
      .center    (rd_data_ff),
      .center_ok (rd_ok_ff),
      .lane_en   (lane_en_ff),
      .out_tag   (dist_tag),
      .out_sum   (dist_sum)
   );

   // Running minimum; strict compare keeps the lower index on a tie
   always_ff @(posedge clock) begin
      if (req_fire && req_data.func == FUNC_CLASSIFY) begin
         cmp_idx_ff <= '0;
      end else if (dist_tag.vld) begin
         cmp_idx_ff <= cmp_idx_ff + CIDX_W'(1);
         if (cmp_idx_ff == '0 || dist_sum < best_sum_ff) begin
            best_sum_ff <= dist_sum;
            best_idx_ff <= cmp_idx_ff;
         end
      end
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_data.func == FUNC_CLASSIFY) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (dist_tag.vld && dist_tag.last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.nearest_slot <= SLOT_W'(best_idx_ff);
         rsp_data_ff.best_dist_sq <= DIST_W'(best_sum_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Distances arrive only while a scan is running
   a_dist_in_scan: assert property (@(posedge clock) disable iff (reset)
      dist_tag.vld |-> (state_ff == S_SCAN))
      else $error("distance result outside a scan");

   // Reads never run past the last center in range
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_on_ff |-> (rd_idx_ff <= last_idx_ff))
      else $error("center read beyond search range");

   // The winner lies inside the scanned range
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (best_idx_ff <= last_idx_ff))
      else $error("nearest index beyond search range");

   // A new response comes only out of a finished scan
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised without a finished scan");

   // No request is taken while reads are being issued
   a_no_accept_scan: assert property (@(posedge clock) disable iff (reset)
      issue_on_ff |-> !req_ready)
      else $error("request accepted during a scan");

endmodule

`default_nettype wire
